// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one classified request passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } req_t;

  typedef logic [31:0] word_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

// File: rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Accepts input requests, drops empty non-last ones, queues the rest.
// ----------------------------------------------------------------------------
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  input  logic       in_no_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output req_t       q_req
);

  req_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop, keep;

  assign in_ready = (cnt_r != (QAW+1)'(QDEPTH));
  // an item with no byte and no last does nothing
  assign keep    = in_last || !in_no_byte;
  assign push    = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_valid && q_ready;
  assign q_req   = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data_byte: in_data_byte, has_byte: !in_no_byte, last: in_last};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule

// File: rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Packs bytes, pads, runs 64 rounds per block and emits digest words.
// ----------------------------------------------------------------------------
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  typedef enum logic [2:0] {
    ST_BYTE, ST_PAD, ST_ROUND, ST_OUT
  } state_t;

  state_t      state_r;
  word_t       h_r [8];
  word_t       w_r [16];
  word_t       a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [63:0] plen_r;
  logic [5:0]  rnd_r;
  logic        pad_r;     // padding in progress for a final block
  logic        padx_r;    // 0x80 already placed
  logic        lenok_r;   // current pad block carries the length field
  logic [2:0]  oidx_r;

  logic       wr_byte;
  logic [7:0] wr_val;
  word_t      t1, t2, wnew;

  // schedule as a 16-word shift window
  assign wnew = sig1(w_r[14]) + w_r[9] + sig0(w_r[1]) + w_r[0];
  assign t1 = hh_r + bsig1(e_r) + ((e_r & f_r) ^ (~e_r & g_r)) + K_TAB[rnd_r] + w_r[0];
  assign t2 = bsig0(a_r) + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  assign q_ready         = (state_r == ST_BYTE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_final_word  = (oidx_r == 3'd7);

  // byte written this cycle in byte or pad state
  always_comb begin
    wr_byte = 1'b0;
    wr_val  = 8'h00;
    if (state_r == ST_BYTE && q_valid && q_req.has_byte) begin
      wr_byte = 1'b1;
      wr_val  = q_req.data_byte;
    end else if (state_r == ST_PAD) begin
      wr_byte = 1'b1;
      if (!padx_r)                        wr_val = PAD_BYTE;
      else if (lenok_r && pos_r >= 6'd56) wr_val = plen_r[8*(6'd63-pos_r) +: 8];
      else                                wr_val = 8'h00;
    end
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BYTE;
      pos_r   <= '0;
      len_r   <= '0;
      pad_r   <= 1'b0;
      padx_r  <= 1'b0;
      lenok_r <= 1'b0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
    end else begin
      if (wr_byte) begin
        w_r[pos_r[5:2]][8*(3-pos_r[1:0]) +: 8] <= wr_val;
        pos_r <= pos_r + 1'b1;
      end
      case (state_r)
        ST_BYTE: begin
          if (q_valid) begin
            if (q_req.last) begin
              plen_r <= len_r + (q_req.has_byte ? 64'd8 : 64'd0);
              pad_r  <= 1'b1;
              padx_r <= 1'b0;
            end
            if (q_req.has_byte) len_r <= len_r + 64'd8;
            if (q_req.has_byte && pos_r == 6'd63) begin
              state_r <= ST_ROUND;
            end else if (q_req.last) begin
              state_r <= ST_PAD;
            end
          end
          rnd_r <= '0;
          {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
          {e_r, f_r, g_r, hh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
        end
        ST_PAD: begin
          padx_r <= 1'b1;
          // the length fits only when 0x80 lands before byte 56
          if (!padx_r) lenok_r <= (pos_r < 6'd56);
          if (pos_r == 6'd63) begin
            state_r <= ST_ROUND;
          end
          rnd_r <= '0;
          {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
          {e_r, f_r, g_r, hh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
        end
        ST_ROUND: begin
          hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            h_r[0] <= h_r[0] + t1 + t2; h_r[1] <= h_r[1] + a_r;
            h_r[2] <= h_r[2] + b_r;     h_r[3] <= h_r[3] + c_r;
            h_r[4] <= h_r[4] + d_r + t1; h_r[5] <= h_r[5] + e_r;
            h_r[6] <= h_r[6] + f_r;     h_r[7] <= h_r[7] + g_r;
            if (!pad_r) begin
              state_r <= ST_BYTE;
            end else if (padx_r && lenok_r) begin
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_PAD;
              // spill block: 0x80 if not yet placed, zeros, then the length
              if (padx_r) lenok_r <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 1'b1;
            if (oidx_r == 3'd7) begin
              state_r <= ST_BYTE;
              pos_r   <= '0;
              len_r   <= '0;
              pad_r   <= 1'b0;
              padx_r  <= 1'b0;
              lenok_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
            end
          end
        end
        default: state_r <= ST_BYTE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(oidx_r)) else $error("out slip");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !q_ready) else $error("taking during rounds");
  a_rnd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_ROUND) |-> rnd_r == '0) else $error("round count");

endmodule

// File: rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream: front queue plus round engine.
// ----------------------------------------------------------------------------
// one queued byte a cycle into the block; a full block halts intake during rounds
// padding writes one pad byte at a time (up to 72), then 64 rounds per pad block
// digest: eight words, one per cycle when out_ready, after the final block's rounds
// the single shared round unit runs each block's rounds while byte intake waits
// synchronous active-low reset loads the initial hash and empties the queue
module sha256_message_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic        in_no_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);

  logic q_valid, q_ready;
  req_t q_req;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last, .in_no_byte,
    .q_valid, .q_ready, .q_req
  );

  sha_core u_core (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_final_word
  );

endmodule
